FILE: design/tslm_pkg.sv
// Shared types, constants and codes of the two-axis line mover.
package tslm_pkg;

   localparam int POSITION_BITS   = 20;
   localparam int DELAY_BITS      = 16;
   localparam int TARGET_BITS     = POSITION_BITS + 1;
   localparam int ERROR_BITS      = POSITION_BITS + 2;
   localparam int PRODUCT_BITS    = POSITION_BITS + DELAY_BITS;
   localparam int DIV_COUNT_BITS  = $clog2(DELAY_BITS);
   localparam int CSR_ADDR_BITS   = 4;
   localparam int CSR_DATA_BITS   = 32;
   localparam int RAMP_STEPS_INIT = 1000;

   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_STEP  = 2'd1,
      OP_STOP  = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_RUN     = 3'd0,
      ST_DONE    = 3'd1,
      ST_X_RANGE = 3'd2,
      ST_Y_RANGE = 3'd3,
      ST_STOPPED = 3'd4,
      ST_IDLE    = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      REG_MAX_POS_X  = 2'd0,
      REG_MAX_POS_Y  = 2'd1,
      REG_RAMP_STEPS = 2'd2
   } reg_index_type;

   typedef enum logic [2:0] {
      CS_IDLE,
      CS_DECODE,
      CS_DIV_GO,
      CS_DIV_WAIT,
      CS_APPLY,
      CS_RESP
   } ctrl_state_type;

   typedef struct packed {
      logic capture;
      logic decode;
      logic div_start;
      logic apply;
   } ctrl_cmd_type;

   typedef struct packed {
      logic need_div;
      logic div_done;
   } ctrl_stat_type;

endpackage

FILE: design/tslm_if.sv
// Request and response channel interfaces of the line mover.
interface tslm_req_if;
   logic                                   valid;
   logic                                   ready;
   logic [1:0]                             opcode;
   logic signed [tslm_pkg::TARGET_BITS-1:0] target_x;
   logic signed [tslm_pkg::TARGET_BITS-1:0] target_y;
   logic [tslm_pkg::DELAY_BITS-1:0]        fast_delay;
   logic [tslm_pkg::DELAY_BITS-1:0]        slow_delay;

   modport source (output valid, opcode, target_x, target_y, fast_delay, slow_delay,
                   input ready);
   modport sink (input valid, opcode, target_x, target_y, fast_delay, slow_delay,
                 output ready);
endinterface

interface tslm_rsp_if;
   logic                               valid;
   logic                               ready;
   logic                               step_x;
   logic                               step_y;
   logic                               dir_x;
   logic                               dir_y;
   logic [tslm_pkg::DELAY_BITS-1:0]    step_delay;
   logic [tslm_pkg::POSITION_BITS-1:0] pos_x;
   logic [tslm_pkg::POSITION_BITS-1:0] pos_y;
   logic [2:0]                         status;

   modport source (output valid, step_x, step_y, dir_x, dir_y, step_delay, pos_x, pos_y,
                   status, input ready);
   modport sink (input valid, step_x, step_y, dir_x, dir_y, step_delay, pos_x, pos_y,
                 status, output ready);
endinterface

FILE: design/tslm_div.sv
// Restoring divider, one quotient bit per cycle, for the ramp delay.
module tslm_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [tslm_pkg::PRODUCT_BITS-1:0]   numer,
   input  logic [tslm_pkg::POSITION_BITS-1:0]  denom,
   output logic                                done,
   output logic [tslm_pkg::DELAY_BITS-1:0]     quot
);

   logic                                 busy_ff, busy_in;
   logic [tslm_pkg::DIV_COUNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [tslm_pkg::POSITION_BITS-1:0]   rem_ff, rem_in;
   logic [tslm_pkg::DELAY_BITS-1:0]      q_ff, q_in;
   logic [tslm_pkg::POSITION_BITS:0]     trial;
   logic                                 fits;

   // numer < denom << DELAY_BITS, so the high part already sits below denom
   always_comb begin
      trial   = {rem_ff, q_ff[tslm_pkg::DELAY_BITS-1]};
      fits    = trial >= {1'b0, denom};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = numer[tslm_pkg::PRODUCT_BITS-1:tslm_pkg::DELAY_BITS];
         q_in    = numer[tslm_pkg::DELAY_BITS-1:0];
      end else if (busy_ff) begin
         rem_in = fits ? tslm_pkg::POSITION_BITS'(trial - {1'b0, denom})
                       : trial[tslm_pkg::POSITION_BITS-1:0];
         q_in   = {q_ff[tslm_pkg::DELAY_BITS-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == tslm_pkg::DIV_COUNT_BITS'(tslm_pkg::DELAY_BITS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      q_ff   <= q_in;
   end

   assign done = ~busy_ff;
   assign quot = q_ff;

endmodule

FILE: design/tslm_dp.sv
// Datapath: move state, Bresenham update, ramp delay and result registers.
module tslm_dp (
   input  logic                                      clock,
   input  logic                                      reset,
   input  tslm_pkg::ctrl_cmd_type                    cmd,
   output tslm_pkg::ctrl_stat_type                   stat,
   input  logic [1:0]                                opcode,
   input  logic signed [tslm_pkg::TARGET_BITS-1:0]   target_x,
   input  logic signed [tslm_pkg::TARGET_BITS-1:0]   target_y,
   input  logic [tslm_pkg::DELAY_BITS-1:0]           fast_delay,
   input  logic [tslm_pkg::DELAY_BITS-1:0]           slow_delay,
   input  logic [tslm_pkg::POSITION_BITS-1:0]        max_pos_x,
   input  logic [tslm_pkg::POSITION_BITS-1:0]        max_pos_y,
   input  logic [tslm_pkg::POSITION_BITS-1:0]        ramp_steps,
   output logic                                      step_x,
   output logic                                      step_y,
   output logic                                      dir_x,
   output logic                                      dir_y,
   output logic [tslm_pkg::DELAY_BITS-1:0]           step_delay,
   output logic [tslm_pkg::POSITION_BITS-1:0]        pos_x,
   output logic [tslm_pkg::POSITION_BITS-1:0]        pos_y,
   output logic [2:0]                                status
);

   localparam int PB = tslm_pkg::POSITION_BITS;
   localparam int DB = tslm_pkg::DELAY_BITS;
   localparam int EB = tslm_pkg::ERROR_BITS;

   // latched request
   tslm_pkg::op_type        op_ff;
   logic [PB:0]             tx_ff, ty_ff;
   logic [DB-1:0]           fast_req_ff, slow_req_ff;

   // move state
   logic [PB-1:0]           pos_x_ff, pos_y_ff, goal_x_ff, goal_y_ff;
   logic [PB-1:0]           span_x_ff, span_y_ff;
   logic signed [EB-1:0]    err_ff;
   logic                    head_x_ff, head_y_ff;
   logic [PB-1:0]           idx_ff, total_ff, ramp_ff;
   logic [DB-1:0]           fast_ff, slow_ff;
   logic                    moving_ff;

   // ramp operands
   logic [tslm_pkg::PRODUCT_BITS-1:0] prod_ff, prod_c;
   logic [DB-1:0]           base_ff;
   logic                    neg_ff, div_ff;

   // results
   logic                    step_x_ff, step_y_ff;
   logic [DB-1:0]           delay_ff;
   tslm_pkg::status_type    status_ff;

   // decode terms
   logic                    br_up, br_down, need_div;
   logic [PB-1:0]           down_start, k_c;
   logic [DB-1:0]           mag_c;
   logic                    fast_lt_slow;

   // divider
   logic                    div_done;
   logic [DB-1:0]           quot;

   // start terms
   logic                    x_bad, y_bad;
   logic [PB-1:0]           dx_c, dy_c, steps_c, ramp_c;
   logic signed [EB-1:0]    err_start;

   // step terms
   logic signed [EB:0]      e2, neg_dy, span_x_s;
   logic                    cx, cy;
   logic signed [EB-1:0]    err_step;
   logic [PB-1:0]           px_step, py_step, px_fin, py_fin, idx_next;
   logic                    at_end, arrived;
   logic [DB-1:0]           dly_c;

   always_comb begin
      down_start   = total_ff - ramp_ff;
      br_up        = idx_ff < ramp_ff;
      br_down      = idx_ff > down_start;
      need_div     = (op_ff == tslm_pkg::OP_STEP) && moving_ff && (br_up || br_down);
      k_c          = br_up ? idx_ff : idx_ff - down_start;
      fast_lt_slow = fast_ff < slow_ff;
      mag_c        = fast_lt_slow ? slow_ff - fast_ff : fast_ff - slow_ff;
      prod_c       = {{DB{1'b0}}, k_c} * {{PB{1'b0}}, mag_c};
   end

   always_ff @(posedge clock) begin
      if (cmd.decode) begin
         prod_ff <= prod_c;
         base_ff <= br_up ? slow_ff : fast_ff;
         neg_ff  <= br_up ? fast_lt_slow : (slow_ff < fast_ff);
         div_ff  <= need_div;
      end
   end

   tslm_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .numer (prod_ff),
      .denom (ramp_ff),
      .done  (div_done),
      .quot  (quot)
   );

   assign stat.need_div = need_div;
   assign stat.div_done = div_done;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff       <= tslm_pkg::op_type'(opcode);
         tx_ff       <= target_x;
         ty_ff       <= target_y;
         fast_req_ff <= fast_delay;
         slow_req_ff <= slow_delay;
      end
   end

   // start of a move
   always_comb begin
      x_bad     = tx_ff[PB] || (tx_ff[PB-1:0] > max_pos_x);
      y_bad     = ty_ff[PB] || (ty_ff[PB-1:0] > max_pos_y);
      dx_c      = (tx_ff[PB-1:0] >= pos_x_ff) ? tx_ff[PB-1:0] - pos_x_ff
                                               : pos_x_ff - tx_ff[PB-1:0];
      dy_c      = (ty_ff[PB-1:0] >= pos_y_ff) ? ty_ff[PB-1:0] - pos_y_ff
                                               : pos_y_ff - ty_ff[PB-1:0];
      steps_c   = (dx_c >= dy_c) ? dx_c : dy_c;
      ramp_c    = ({1'b0, steps_c} < {ramp_steps, 1'b0}) ? (steps_c >> 1) : ramp_steps;
      err_start = $signed({2'b00, dx_c}) - $signed({2'b00, dy_c});
   end

   // one Bresenham iteration
   always_comb begin
      e2       = {err_ff, 1'b0};
      neg_dy   = -$signed({3'b000, span_y_ff});
      span_x_s = $signed({3'b000, span_x_ff});
      cx       = e2 > neg_dy;
      cy       = e2 < span_x_s;
      err_step = err_ff;
      if (cx) begin
         err_step = err_step - $signed({2'b00, span_y_ff});
      end
      if (cy) begin
         err_step = err_step + $signed({2'b00, span_x_ff});
      end
      px_step  = cx ? (head_x_ff ? pos_x_ff + 1'b1 : pos_x_ff - 1'b1) : pos_x_ff;
      py_step  = cy ? (head_y_ff ? pos_y_ff + 1'b1 : pos_y_ff - 1'b1) : pos_y_ff;
      idx_next = idx_ff + 1'b1;
      at_end   = idx_next >= total_ff;
      px_fin   = at_end ? goal_x_ff : px_step;
      py_fin   = at_end ? goal_y_ff : py_step;
      arrived  = (px_fin == goal_x_ff) && (py_fin == goal_y_ff);
      if (div_ff) begin
         dly_c = neg_ff ? base_ff - quot : base_ff + quot;
      end else begin
         dly_c = fast_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff  <= '0;
         pos_y_ff  <= '0;
         goal_x_ff <= '0;
         goal_y_ff <= '0;
         span_x_ff <= '0;
         span_y_ff <= '0;
         err_ff    <= '0;
         head_x_ff <= 1'b0;
         head_y_ff <= 1'b0;
         idx_ff    <= '0;
         total_ff  <= '0;
         ramp_ff   <= '0;
         fast_ff   <= '0;
         slow_ff   <= '0;
         moving_ff <= 1'b0;
      end else if (cmd.apply) begin
         unique case (op_ff)
            tslm_pkg::OP_START: begin
               if (!x_bad && !y_bad) begin
                  head_x_ff <= pos_x_ff < tx_ff[PB-1:0];
                  head_y_ff <= pos_y_ff < ty_ff[PB-1:0];
                  goal_x_ff <= tx_ff[PB-1:0];
                  goal_y_ff <= ty_ff[PB-1:0];
                  span_x_ff <= dx_c;
                  span_y_ff <= dy_c;
                  err_ff    <= err_start;
                  total_ff  <= steps_c;
                  ramp_ff   <= ramp_c;
                  idx_ff    <= '0;
                  fast_ff   <= fast_req_ff;
                  slow_ff   <= slow_req_ff;
                  moving_ff <= steps_c != '0;
               end
            end
            tslm_pkg::OP_STEP: begin
               if (moving_ff) begin
                  err_ff    <= err_step;
                  pos_x_ff  <= px_fin;
                  pos_y_ff  <= py_fin;
                  idx_ff    <= idx_next;
                  moving_ff <= ~arrived;
               end
            end
            tslm_pkg::OP_STOP: begin
               moving_ff <= 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.apply) begin
         step_x_ff <= 1'b0;
         step_y_ff <= 1'b0;
         delay_ff  <= '0;
         unique case (op_ff)
            tslm_pkg::OP_START: begin
               if (x_bad) begin
                  status_ff <= tslm_pkg::ST_X_RANGE;
               end else if (y_bad) begin
                  status_ff <= tslm_pkg::ST_Y_RANGE;
               end else begin
                  status_ff <= (steps_c != '0) ? tslm_pkg::ST_RUN : tslm_pkg::ST_DONE;
               end
            end
            tslm_pkg::OP_STEP: begin
               if (moving_ff) begin
                  step_x_ff <= cx;
                  step_y_ff <= cy;
                  delay_ff  <= dly_c;
                  status_ff <= arrived ? tslm_pkg::ST_DONE : tslm_pkg::ST_RUN;
               end else begin
                  status_ff <= tslm_pkg::ST_IDLE;
               end
            end
            tslm_pkg::OP_STOP: begin
               status_ff <= tslm_pkg::ST_STOPPED;
            end
            default: begin
               status_ff <= tslm_pkg::ST_IDLE;
            end
         endcase
      end
   end

   // direction and position come straight from the state, which holds
   // until the response transfer completes
   assign step_x     = step_x_ff;
   assign step_y     = step_y_ff;
   assign dir_x      = head_x_ff;
   assign dir_y      = head_y_ff;
   assign step_delay = delay_ff;
   assign pos_x      = pos_x_ff;
   assign pos_y      = pos_y_ff;
   assign status     = status_ff;

endmodule

FILE: design/tslm_ctrl.sv
// Controller: sequences capture, decode, division, update and response.
module tslm_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  tslm_pkg::ctrl_stat_type   stat,
   output tslm_pkg::ctrl_cmd_type    cmd
);

   tslm_pkg::ctrl_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tslm_pkg::CS_IDLE: begin
            if (req_valid) begin
               state_in = tslm_pkg::CS_DECODE;
            end
         end
         tslm_pkg::CS_DECODE: begin
            state_in = stat.need_div ? tslm_pkg::CS_DIV_GO : tslm_pkg::CS_APPLY;
         end
         tslm_pkg::CS_DIV_GO: begin
            state_in = tslm_pkg::CS_DIV_WAIT;
         end
         tslm_pkg::CS_DIV_WAIT: begin
            if (stat.div_done) begin
               state_in = tslm_pkg::CS_APPLY;
            end
         end
         tslm_pkg::CS_APPLY: begin
            state_in = tslm_pkg::CS_RESP;
         end
         tslm_pkg::CS_RESP: begin
            if (rsp_ready) begin
               state_in = tslm_pkg::CS_IDLE;
            end
         end
         default: begin
            state_in = tslm_pkg::CS_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready     = state_ff == tslm_pkg::CS_IDLE;
      rsp_valid     = state_ff == tslm_pkg::CS_RESP;
      cmd.capture   = (state_ff == tslm_pkg::CS_IDLE) && req_valid;
      cmd.decode    = state_ff == tslm_pkg::CS_DECODE;
      cmd.div_start = state_ff == tslm_pkg::CS_DIV_GO;
      cmd.apply     = state_ff == tslm_pkg::CS_APPLY;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tslm_pkg::CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: design/two_axis_stepper_line_mover_unit.sv
// Two-axis line mover: one item at a time through a controller and datapath.
// Start, stop, idle and full-speed step items go from the request transfer through the
// decode, apply and response states. Step items inside a ramp also launch and wait on
// the bit-serial ramp divider (16 quotient bits) between decode and apply. The next
// request is taken the cycle after the response transfer.
// Synchronous reset: not moving, position zero, limits all ones, ramp length 1000.
module two_axis_stepper_line_mover_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   tslm_req_if.sink                             req,
   tslm_rsp_if.source                           rsp,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [tslm_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [tslm_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [tslm_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                 csr_pready
);

   localparam int PB = tslm_pkg::POSITION_BITS;

   logic [PB-1:0]                  max_x_ff, max_y_ff, ramp_steps_ff;
   logic                           csr_write;
   tslm_pkg::reg_index_type        csr_index;
   tslm_pkg::ctrl_cmd_type         cmd;
   tslm_pkg::ctrl_stat_type        stat;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = tslm_pkg::reg_index_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         max_x_ff      <= '1;
         max_y_ff      <= '1;
         ramp_steps_ff <= PB'(tslm_pkg::RAMP_STEPS_INIT);
      end else if (csr_write) begin
         unique case (csr_index)
            tslm_pkg::REG_MAX_POS_X:  max_x_ff      <= csr_pwdata[PB-1:0];
            tslm_pkg::REG_MAX_POS_Y:  max_y_ff      <= csr_pwdata[PB-1:0];
            tslm_pkg::REG_RAMP_STEPS: ramp_steps_ff <= csr_pwdata[PB-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         tslm_pkg::REG_MAX_POS_X:  csr_prdata = tslm_pkg::CSR_DATA_BITS'(max_x_ff);
         tslm_pkg::REG_MAX_POS_Y:  csr_prdata = tslm_pkg::CSR_DATA_BITS'(max_y_ff);
         tslm_pkg::REG_RAMP_STEPS: csr_prdata = tslm_pkg::CSR_DATA_BITS'(ramp_steps_ff);
         default:                  csr_prdata = '0;
      endcase
   end

   tslm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   tslm_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .opcode     (req.opcode),
      .target_x   (req.target_x),
      .target_y   (req.target_y),
      .fast_delay (req.fast_delay),
      .slow_delay (req.slow_delay),
      .max_pos_x  (max_x_ff),
      .max_pos_y  (max_y_ff),
      .ramp_steps (ramp_steps_ff),
      .step_x     (rsp.step_x),
      .step_y     (rsp.step_y),
      .dir_x      (rsp.dir_x),
      .dir_y      (rsp.dir_y),
      .step_delay (rsp.step_delay),
      .pos_x      (rsp.pos_x),
      .pos_y      (rsp.pos_y),
      .status     (rsp.status)
   );

endmodule
